[sv/annb_pkg.sv]
// Shared types and constants of the Annex B unit splitter.
`default_nettype none

package annb_pkg;

  // Fixed widths of the result fields on the output stream.
  localparam int PAY_W = 24;
  localparam int OFF_W = 32;

  localparam logic STATUS_UNIT = 1'b0;
  localparam logic STATUS_ERR  = 1'b1;

  localparam logic [2:0] PREFIX3 = 3'd3;
  localparam logic [2:0] PREFIX4 = 3'd4;

  localparam logic [7:0] HDR_FORBID = 8'h80;
  localparam logic [7:0] HDR_PRIO   = 8'h60;
  localparam logic [7:0] HDR_TYPE   = 8'h1f;

  typedef struct packed {
    logic             status;
    logic             forbidden;
    logic [1:0]       ref_priority;
    logic [4:0]       unit_type;
    logic [PAY_W-1:0] payload_length;
    logic [2:0]       prefix_length;
    logic [PAY_W-1:0] total_length;
    logic [OFF_W-1:0] unit_offset;
  } res_t;

endpackage

`default_nettype wire

[sv/annb_in_reg.sv]
// Input register stage that takes stream bytes and hands them to the parser.
`default_nettype none

module annb_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,    // data_byte
  input  wire logic       s_tlast,    // stream_end
  input  wire logic       drain_ok,
  output logic            step,
  output logic [7:0]      data_byte,
  output logic            stream_end
);

  logic valid;

  assign step     = valid && drain_ok;
  assign s_tready = !valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (step) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data_byte  <= s_tdata;
      stream_end <= s_tlast;
    end
  end

endmodule

`default_nettype wire

[sv/annb_parse.sv]
// Start code detector, unit counters, result formatting: one byte per cycle of step.
`default_nettype none

module annb_parse import annb_pkg::*; #(
  parameter int LEN_BITS    = 24,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       stream_end,
  output res_t            res,
  output logic            res_valid
);

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_UNIT = 2'd1,
    PH_HUNT = 2'd2
  } phase_t;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  phase_t                 phase,       phase_next;
  logic [1:0]             lead_count,  lead_count_next;
  logic [1:0]             zero_run,    zero_run_next;
  logic [LEN_BITS-1:0]    unit_bytes,  unit_bytes_next;
  logic [2:0]             unit_prefix, unit_prefix_next;
  logic [7:0]             header_byte, header_byte_next;
  logic [OFFSET_BITS-1:0] unit_start,  unit_start_next;
  logic [OFFSET_BITS-1:0] stream_pos;

  logic                   is_zero, is_one, start_hit;
  logic [1:0]             zero_run_inc;
  logic [2:0]             hit_prefix, begin_prefix;
  logic [LEN_BITS-1:0]    hit_back;
  logic                   do_begin, emit, emit_err, emit_empty;
  logic [7:0]             emit_hdr;
  logic [LEN_BITS-1:0]    emit_pay;
  logic [2:0]             emit_prefix;
  logic [OFFSET_BITS-1:0] emit_off;

  assign is_zero      = (data_byte == 8'd0);
  assign is_one       = (data_byte == 8'd1);
  assign start_hit    = is_one && (zero_run >= 2'd2);
  assign zero_run_inc = !is_zero ? 2'd0 : ((zero_run == 2'd3) ? 2'd3 : zero_run + 2'd1);
  assign hit_prefix   = (zero_run == 2'd3) ? PREFIX4 : PREFIX3;
  assign hit_back     = LEN_BITS'(hit_prefix) - LEN_BITS'(1);

  always_comb begin
    phase_next       = phase;
    lead_count_next  = lead_count;
    zero_run_next    = zero_run;
    unit_bytes_next  = unit_bytes;
    unit_prefix_next = unit_prefix;
    header_byte_next = header_byte;
    unit_start_next  = unit_start;
    do_begin         = 1'b0;
    begin_prefix     = PREFIX3;
    emit             = 1'b0;
    emit_err         = 1'b0;
    emit_empty       = 1'b0;
    emit_hdr         = header_byte;
    emit_pay         = '0;
    emit_prefix      = unit_prefix;
    emit_off         = unit_start;

    unique case (phase)
      PH_LEAD: begin
        logic ok;
        logic done;
        logic [2:0] np;
        done = 1'b0;
        np   = PREFIX3;
        if (lead_count < 2'd2) begin
          ok = is_zero;
        end else if (lead_count == 2'd2) begin
          ok   = is_zero || is_one;
          done = is_one;
        end else begin
          ok   = is_one;
          done = is_one;
          np   = PREFIX4;
        end
        if (!ok) begin
          emit_err      = 1'b1;
          phase_next    = PH_HUNT;
          zero_run_next = is_zero ? 2'd3 : 2'd0;
        end else if (done) begin
          do_begin     = 1'b1;
          begin_prefix = np;
          emit_empty   = stream_end;
        end else begin
          lead_count_next = lead_count + 2'd1;
          emit_err        = stream_end;
        end
      end
      PH_UNIT: begin
        if (start_hit) begin
          emit         = 1'b1;
          do_begin     = 1'b1;
          begin_prefix = hit_prefix;
          if (unit_bytes == LEN_MAX) begin
            emit_pay = LEN_MAX;
          end else if (unit_bytes >= hit_back) begin
            emit_pay = unit_bytes - hit_back;
          end else begin
            emit_pay = '0;
          end
        end else begin
          if (unit_bytes == '0) begin
            header_byte_next = data_byte;
          end
          if (unit_bytes != LEN_MAX) begin
            unit_bytes_next = unit_bytes + LEN_BITS'(1);
          end
          zero_run_next = zero_run_inc;
          emit          = stream_end;
          emit_hdr      = header_byte_next;
          emit_pay      = unit_bytes_next;
        end
      end
      default: begin
        // Hunting for a start code; the unused phase code behaves the same.
        if (start_hit) begin
          do_begin     = 1'b1;
          begin_prefix = hit_prefix;
          emit_empty   = stream_end;
        end else begin
          zero_run_next = zero_run_inc;
        end
      end
    endcase

    if (do_begin) begin
      phase_next       = PH_UNIT;
      unit_prefix_next = begin_prefix;
      unit_start_next  = stream_pos - OFFSET_BITS'(begin_prefix - 3'd1);
      unit_bytes_next  = '0;
      zero_run_next    = 2'd0;
      header_byte_next = 8'd0;
    end

    // A start code completed on the final byte reports an empty unit.
    if (emit_empty) begin
      emit        = 1'b1;
      emit_hdr    = 8'd0;
      emit_pay    = '0;
      emit_prefix = begin_prefix;
      emit_off    = unit_start_next;
    end
  end

  always_comb begin
    logic [7:0]          hdr_eff;
    logic [7:0]          fb, pr, ut;
    logic [LEN_BITS:0]   total_wide;
    logic [LEN_BITS-1:0] total_sat;
    hdr_eff    = (emit_pay == '0) ? 8'd0 : emit_hdr;
    fb         = hdr_eff & HDR_FORBID;
    pr         = hdr_eff & HDR_PRIO;
    ut         = hdr_eff & HDR_TYPE;
    total_wide = {1'b0, emit_pay} + (LEN_BITS + 1)'(emit_prefix);
    total_sat  = (total_wide > {1'b0, LEN_MAX}) ? LEN_MAX : total_wide[LEN_BITS-1:0];
    if (emit_err) begin
      res        = '0;
      res.status = STATUS_ERR;
    end else begin
      res.status         = STATUS_UNIT;
      res.forbidden      = fb[7];
      res.ref_priority   = pr[6:5];
      res.unit_type      = ut[4:0];
      res.payload_length = PAY_W'(emit_pay);
      res.prefix_length  = emit_prefix;
      res.total_length   = PAY_W'(total_sat);
      res.unit_offset    = OFF_W'(emit_off);
    end
  end

  assign res_valid = step && (emit || emit_err);

  always_ff @(posedge clk) begin
    if (rst || (step && stream_end)) begin
      phase       <= PH_LEAD;
      lead_count  <= 2'd0;
      zero_run    <= 2'd0;
      unit_bytes  <= '0;
      unit_prefix <= PREFIX3;
      header_byte <= 8'd0;
      unit_start  <= '0;
      stream_pos  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      lead_count  <= lead_count_next;
      zero_run    <= zero_run_next;
      unit_bytes  <= unit_bytes_next;
      unit_prefix <= unit_prefix_next;
      header_byte <= header_byte_next;
      unit_start  <= unit_start_next;
      stream_pos  <= stream_pos + OFFSET_BITS'(1);
    end
  end

  a_prefix_legal: assert property (@(posedge clk) disable iff (rst)
    unit_prefix == PREFIX3 || unit_prefix == PREFIX4)
    else $error("unit prefix length is neither three nor four");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    step && stream_end |=> phase == PH_LEAD && stream_pos == '0 && lead_count == 2'd0)
    else $error("state did not return to the leading start code after the final byte");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == STATUS_ERR |->
      res.payload_length == '0 && res.total_length == '0 && res.unit_offset == '0)
    else $error("error result carries nonzero fields");

endmodule

`default_nettype wire

[sv/annb_out_reg.sv]
// Result register that holds one finished item for the output stream.
`default_nettype none

module annb_out_reg import annb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire res_t       res_in,
  output logic            drain_ok,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [95:0]     m_tdata,   // forbidden, ref_priority, unit_type, payload_length,
                                     // prefix_length, total_length, unit_offset, zero fill
  output logic            m_tuser    // status
);

  res_t held;

  assign drain_ok = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res_in;
    end
  end

  assign m_tuser = held.status;
  assign m_tdata = {5'd0, held.unit_offset, held.total_length, held.prefix_length,
                    held.payload_length, held.unit_type, held.ref_priority, held.forbidden};

endmodule

`default_nettype wire

[sv/annexb_nal_unit_splitter_top.sv]
// Top level of the Annex B unit splitter: input register, parser and result register.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  s_tdata = data_byte, s_tlast = stream_end
//   m_*      out        m_tvalid/m_tready  m_tdata = unit record fields, m_tuser = status
//
// One byte is taken every cycle while the result register drains; the parser state
// update is a single registered stage. A result is presented on m_* once the byte which
// closes the unit has stepped the parser and the result register has loaded it.
// Reset is synchronous and clears the parser to wait for a leading start code.
// When the result register holds an item that is not taken, the input register stalls
// and s_tready falls once it is full.
`default_nettype none

module annexb_nal_unit_splitter_top import annb_pkg::*; #(
  parameter int LEN_BITS    = 24,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // data_byte
  input  wire logic        s_tlast,    // stream_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,    // forbidden, ref_priority, unit_type, payload_length,
                                       // prefix_length, total_length, unit_offset, zero fill
  output logic             m_tuser     // status
);

  logic       drain_ok;
  logic       step;
  logic [7:0] data_byte;
  logic       stream_end;
  res_t       res;
  logic       res_valid;

  annb_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .drain_ok   (drain_ok),
    .step       (step),
    .data_byte  (data_byte),
    .stream_end (stream_end)
  );

  annb_parse #(
    .LEN_BITS    (LEN_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .res        (res),
    .res_valid  (res_valid)
  );

  annb_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res_in   (res),
    .drain_ok (drain_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
